// ----- rtl/core/gpa_pkg.sv -----
// ----------------------------------------------------------------------------
// gpa_pkg
// shared widths, codes and controller/datapath handshake types for the
// gf(2) polynomial alu
// ----------------------------------------------------------------------------
package gpa_pkg;

  // polynomial width, bit i holds the coefficient of x^i
  localparam int WIDTH   = 32;
  localparam int PROD_W  = 2 * WIDTH - 1;
  localparam int CNT_W   = $clog2(WIDTH);

  // fixed field widths of the channels
  localparam int OP_W    = 2;
  localparam int OPND_W  = 32;
  localparam int PRIM_W  = 63;
  localparam int REM_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2,
    OP_CMP = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_DIV,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul_step;
    logic norm_step;
    logic div_step;
    logic publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic cnt_zero;
    logic d_top;
    logic b_zero;
  } status_t;

endpackage

// ----- rtl/core/gpa_if.sv -----
// ----------------------------------------------------------------------------
// gpa_if
// valid/ready channels carrying operand words and result words
// ----------------------------------------------------------------------------
interface gpa_in_if;
  logic                      valid;
  logic                      ready;
  logic [gpa_pkg::OP_W-1:0]   op;
  logic [gpa_pkg::OPND_W-1:0] operand_a;
  logic [gpa_pkg::OPND_W-1:0] operand_b;

  modport source (output valid, output op, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input op, input operand_a, input operand_b,
                  output ready);
endinterface

interface gpa_out_if;
  logic                      valid;
  logic                      ready;
  logic [gpa_pkg::PRIM_W-1:0] primary;
  logic [gpa_pkg::REM_W-1:0]  remainder;
  logic                      less;
  logic                      equal;
  logic                      divide_error;

  modport source (output valid, output primary, output remainder, output less,
                  output equal, output divide_error, input ready);
  modport sink   (input valid, input primary, input remainder, input less,
                  input equal, input divide_error, output ready);
endinterface

// ----- rtl/core/gf2_polynomial_alu_core.sv -----
// ----------------------------------------------------------------------------
// gf2_polynomial_alu_core
// add, carry-less multiply, long divide and compare of gf(2) polynomials
// ----------------------------------------------------------------------------
// One item at a time: a word is taken on in_ch when the unit is idle, and its
// result word is held in an output register until out_ch takes it, so the
// next word may already be in work while a result waits. Multiply runs one
// shift-and-xor step per coefficient of operand_b. Divide first shifts the
// divisor until its leading term sits in the top bit, one bit per cycle, then
// runs one subtract-and-shift step per quotient bit. A zero divisor gives
// divide_error with primary and remainder zero. All loops share the single
// shift/xor datapath.
module gf2_polynomial_alu_core (
  input  logic      clk,
  input  logic      rst_n,
  gpa_in_if.sink    in_ch,
  gpa_out_if.source out_ch
);

  gpa_pkg::cmd_t    cmd;
  gpa_pkg::status_t sts;

  // sequencer
  gpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // operand, loop and result registers
  gpa_datapath u_datapath (
    .clk              (clk),
    .in_op            (in_ch.op),
    .in_operand_a     (in_ch.operand_a),
    .in_operand_b     (in_ch.operand_b),
    .cmd              (cmd),
    .sts              (sts),
    .out_primary      (out_ch.primary),
    .out_remainder    (out_ch.remainder),
    .out_less         (out_ch.less),
    .out_equal        (out_ch.equal),
    .out_divide_error (out_ch.divide_error)
  );

`ifndef NO_ASSERTIONS
  // a word taken closes the input until that item is finished
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after accepting a word");

  // error result carries no quotient or remainder
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.divide_error) |->
      (out_ch.primary == '0 && out_ch.remainder == '0))
    else $error("divide error with nonzero results");

  // compare flags exclusive, and only on a compare result
  a_cmp_flags : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.less || out_ch.equal)) |->
      (!(out_ch.less && out_ch.equal) && out_ch.primary == '0 &&
       out_ch.remainder == '0 && !out_ch.divide_error))
    else $error("inconsistent compare result");
`endif

endmodule

// ----- rtl/core/gpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// gpa_ctrl
// sequencer for the alu: steps multiply, normalize and divide loops and
// owns the result word valid flag
// ----------------------------------------------------------------------------
module gpa_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [gpa_pkg::OP_W-1:0] in_op,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  gpa_pkg::status_t        sts,
  output gpa_pkg::cmd_t           cmd
);

  gpa_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gpa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (gpa_pkg::op_t'(in_op))
            gpa_pkg::OP_MUL: state_nxt = gpa_pkg::ST_MUL;
            gpa_pkg::OP_DIV: state_nxt = gpa_pkg::ST_NORM;
            default:         state_nxt = gpa_pkg::ST_FIN;
          endcase
        end
      end
      gpa_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.cnt_last) state_nxt = gpa_pkg::ST_FIN;
      end
      gpa_pkg::ST_NORM: begin
        // zero divisor goes straight to the error result
        if (sts.b_zero) begin
          state_nxt = gpa_pkg::ST_FIN;
        end else if (sts.d_top) begin
          state_nxt = gpa_pkg::ST_DIV;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      gpa_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_zero) state_nxt = gpa_pkg::ST_FIN;
      end
      gpa_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = gpa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gpa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/gpa_datapath.sv -----
// ----------------------------------------------------------------------------
// gpa_datapath
// operand registers, shift-and-xor accumulator, divisor normalizer and
// result word register
// ----------------------------------------------------------------------------
module gpa_datapath (
  input  logic                      clk,
  input  logic [gpa_pkg::OP_W-1:0]   in_op,
  input  logic [gpa_pkg::OPND_W-1:0] in_operand_a,
  input  logic [gpa_pkg::OPND_W-1:0] in_operand_b,
  input  gpa_pkg::cmd_t             cmd,
  output gpa_pkg::status_t          sts,
  output logic [gpa_pkg::PRIM_W-1:0] out_primary,
  output logic [gpa_pkg::REM_W-1:0]  out_remainder,
  output logic                      out_less,
  output logic                      out_equal,
  output logic                      out_divide_error
);

  localparam int W     = gpa_pkg::WIDTH;
  localparam int PW    = gpa_pkg::PROD_W;
  localparam int CW    = gpa_pkg::CNT_W;

  gpa_pkg::op_t    op_r, op_nxt;
  logic [W-1:0]    a_r, a_nxt;
  logic [W-1:0]    b_r, b_nxt;
  logic [W-1:0]    d_r, d_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]   acc_r, acc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;

  logic [gpa_pkg::PRIM_W-1:0] prim_r, prim_nxt;
  logic [gpa_pkg::REM_W-1:0]  remo_r, remo_nxt;
  logic                       less_r, less_nxt;
  logic                       equal_r, equal_nxt;
  logic                       err_r, err_nxt;

  logic            qbit;
  logic            b_zero;

  assign qbit   = rem_r[idx_r];
  assign b_zero = (b_r == '0);

  always_comb begin
    op_nxt  = op_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    d_nxt   = d_r;
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (cmd.load) begin
      op_nxt  = gpa_pkg::op_t'(in_op);
      a_nxt   = in_operand_a[W-1:0];
      b_nxt   = in_operand_b[W-1:0];
      d_nxt   = in_operand_b[W-1:0];
      rem_nxt = in_operand_a[W-1:0];
      acc_nxt = '0;
      cnt_nxt = '0;
      idx_nxt = CW'(W - 1);
    end else if (cmd.mul_step) begin
      // msb-first carry-less multiply, b shifts out from the top
      acc_nxt = {acc_r[PW-2:0], 1'b0} ^ (b_r[W-1] ? PW'(a_r) : '0);
      b_nxt   = {b_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.norm_step) begin
      // align divisor leading term to the top bit
      d_nxt   = {d_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.div_step) begin
      if (qbit) rem_nxt = rem_r ^ d_r;
      acc_nxt = {acc_r[PW-2:0], qbit};
      d_nxt   = {1'b0, d_r[W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      idx_nxt = idx_r - 1'b1;
    end
  end

  // result word, formed when the item is finished
  always_comb begin
    prim_nxt  = prim_r;
    remo_nxt  = remo_r;
    less_nxt  = less_r;
    equal_nxt = equal_r;
    err_nxt   = err_r;
    if (cmd.publish) begin
      prim_nxt  = '0;
      remo_nxt  = '0;
      less_nxt  = 1'b0;
      equal_nxt = 1'b0;
      err_nxt   = 1'b0;
      case (op_r)
        gpa_pkg::OP_ADD: prim_nxt = gpa_pkg::PRIM_W'(a_r ^ b_r);
        gpa_pkg::OP_MUL: prim_nxt = gpa_pkg::PRIM_W'(acc_r);
        gpa_pkg::OP_DIV: begin
          if (b_zero) begin
            err_nxt = 1'b1;
          end else begin
            prim_nxt = gpa_pkg::PRIM_W'(acc_r);
            remo_nxt = gpa_pkg::REM_W'(rem_r);
          end
        end
        gpa_pkg::OP_CMP: begin
          less_nxt  = (a_r < b_r);
          equal_nxt = (a_r == b_r);
        end
        default: prim_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    d_r     <= d_nxt;
    rem_r   <= rem_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    idx_r   <= idx_nxt;
    prim_r  <= prim_nxt;
    remo_r  <= remo_nxt;
    less_r  <= less_nxt;
    equal_r <= equal_nxt;
    err_r   <= err_nxt;
  end

  assign sts.cnt_last = (cnt_r == CW'(W - 1));
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.d_top    = d_r[W-1];
  assign sts.b_zero   = b_zero;

  assign out_primary      = prim_r;
  assign out_remainder    = remo_r;
  assign out_less         = less_r;
  assign out_equal        = equal_r;
  assign out_divide_error = err_r;

endmodule
